// ===== rtl/aescd_pkg.sv =====
// Shared types, constants and AES round functions for the AES-128 CTR/CBC block decryptor.
// Depends on nothing; every other file of the block uses it by scoped names.
package aescd_pkg;

   localparam int BLOCK_BYTES = 16;
   localparam int NUM_ROUNDS  = 10;
   localparam int NUM_STAGES  = 2 * NUM_ROUNDS;

   localparam logic [2:0] CSR_KEY_HIGH    = 3'd0;
   localparam logic [2:0] CSR_KEY_LOW     = 3'd1;
   localparam logic [2:0] CSR_IV_HIGH     = 3'd2;
   localparam logic [2:0] CSR_IV_LOW      = 3'd3;
   localparam logic [2:0] CSR_CIPHER_MODE = 3'd4;

   localparam logic MODE_CTR = 1'b0;
   localparam logic MODE_CBC = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_OFFSET  = 2'd1;
   localparam logic [1:0] STATUS_PARTIAL = 2'd2;

   typedef struct packed {
      logic [63:0] data_high;
      logic [63:0] data_low;
      logic [3:0]  start_offset;
      logic [4:0]  byte_count;
      logic        restart;
   } req_type;

   typedef struct packed {
      logic [63:0] plain_high;
      logic [63:0] plain_low;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic         mode;
      logic [1:0]   status;
      logic [15:0]  lane_mask;
      logic [127:0] state;
      logic [127:0] rkey;
      logic [127:0] xor_val;
   } pipe_type;

   typedef struct packed {
      logic [7:0] rcon;
      logic       last_fwd;
      logic       bwd;
      logic       mix;
   } stage_ctl_type;

   localparam logic [7:0] RCON [NUM_ROUNDS] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
   };

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] key_g(input logic [31:0] w, input logic [7:0] rc);
      return {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
   endfunction

   function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] n0, n1, n2, n3;
      n0 = k[127:96] ^ key_g(k[31:0], rc);
      n1 = k[95:64] ^ n0;
      n2 = k[63:32] ^ n1;
      n3 = k[31:0] ^ n2;
      return {n0, n1, n2, n3};
   endfunction

   function automatic logic [127:0] key_bwd(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3;
      w3 = k[31:0] ^ k[63:32];
      w2 = k[63:32] ^ k[95:64];
      w1 = k[95:64] ^ k[127:96];
      w0 = k[127:96] ^ key_g(w3, rc);
      return {w0, w1, w2, w3};
   endfunction

   function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] k,
                                              input logic last);
      logic [7:0]   t [BLOCK_BYTES];
      logic [127:0] r;
      logic [7:0]   all;
      for (int c = 0; c < 4; c++) begin
         for (int rr = 0; rr < 4; rr++) begin
            t[c*4+rr] = SBOX[s[127-8*((((c+rr)&3)*4)+rr) -: 8]];
         end
      end
      for (int c = 0; c < 4; c++) begin
         all = t[c*4] ^ t[c*4+1] ^ t[c*4+2] ^ t[c*4+3];
         for (int rr = 0; rr < 4; rr++) begin
            if (last) begin
               r[127-8*(c*4+rr) -: 8] = t[c*4+rr];
            end else begin
               r[127-8*(c*4+rr) -: 8] = t[c*4+rr] ^ all ^
                                        xtime(t[c*4+rr] ^ t[c*4+((rr+1)&3)]);
            end
         end
      end
      return r ^ k;
   endfunction

   function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] k,
                                              input logic mix);
      logic [127:0] t;
      logic [127:0] r;
      logic [7:0]   a [4];
      logic [7:0]   x2 [4];
      logic [7:0]   x4 [4];
      logic [7:0]   x8 [4];
      for (int c = 0; c < 4; c++) begin
         for (int rr = 0; rr < 4; rr++) begin
            t[127-8*((((c+rr)&3)*4)+rr) -: 8] = INV_SBOX[s[127-8*(c*4+rr) -: 8]];
         end
      end
      t = t ^ k;
      r = t;
      if (mix) begin
         for (int c = 0; c < 4; c++) begin
            for (int rr = 0; rr < 4; rr++) begin
               a[rr]  = t[127-8*(c*4+rr) -: 8];
               x2[rr] = xtime(a[rr]);
               x4[rr] = xtime(x2[rr]);
               x8[rr] = xtime(x4[rr]);
            end
            for (int rr = 0; rr < 4; rr++) begin
               r[127-8*(c*4+rr) -: 8] =
                  (x8[rr] ^ x4[rr] ^ x2[rr]) ^
                  (x8[(rr+1)&3] ^ x2[(rr+1)&3] ^ a[(rr+1)&3]) ^
                  (x8[(rr+2)&3] ^ x4[(rr+2)&3] ^ a[(rr+2)&3]) ^
                  (x8[(rr+3)&3] ^ a[(rr+3)&3]);
            end
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/aescd_round_stage.sv =====
// One pipeline stage of the AES-128 datapath: a key schedule step plus, where the mode needs it, one cipher round.
// Depends on aescd_pkg for the pipeline types and the round functions.
module aescd_round_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  aescd_pkg::stage_ctl_type ctl,
   input  logic                    valid_in,
   input  aescd_pkg::pipe_type     pipe_in,
   output logic                    valid_out,
   output aescd_pkg::pipe_type     pipe_out
);

   logic                valid_ff;
   aescd_pkg::pipe_type pipe_ff;
   aescd_pkg::pipe_type pipe_in_next;
   logic [127:0]        key_next;

   always_comb begin
      pipe_in_next = pipe_in;
      if (ctl.bwd) begin
         key_next = aescd_pkg::key_bwd(pipe_in.rkey, ctl.rcon);
         if (pipe_in.mode == aescd_pkg::MODE_CBC) begin
            pipe_in_next.state = aescd_pkg::dec_round(pipe_in.state, key_next, ctl.mix);
         end
      end else begin
         key_next = aescd_pkg::key_fwd(pipe_in.rkey, ctl.rcon);
         if (pipe_in.mode == aescd_pkg::MODE_CTR) begin
            pipe_in_next.state = aescd_pkg::enc_round(pipe_in.state, key_next, ctl.last_fwd);
         end else if (ctl.last_fwd) begin
            pipe_in_next.state = pipe_in.state ^ key_next;
         end
      end
      pipe_in_next.rkey = key_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         pipe_ff <= pipe_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign pipe_out  = pipe_ff;

endmodule

// ===== rtl/aes128_ctr_cbc_block_decryptor.sv =====
// Top level of the AES-128 CTR/CBC block decryptor: CSRs, chain register, round pipeline.
// Depends on aescd_pkg and aescd_round_stage.
//
// Usage: configure key, IV and cipher_mode through the csr_ port while no transaction is in
// flight, then send ciphertext blocks on the req_ channel (valid/stall). Each request gives
// exactly one response on the rsp_ channel, in order, with plaintext and a status code.
// A request with restart set and an OK status reloads the counter/chain from the IV before
// it is used. The counter or chain is updated when the request is accepted, so consecutive
// blocks follow each other in back-to-back cycles.
// From acceptance to response valid a block passes the entry register, ten forward
// key-schedule/encrypt stages, ten inverse key-schedule/decrypt stages, then the output
// register.
// Throughput: one block per cycle while not stalled; each of the twenty round stages holds
// one block. A rsp_stall while the response register is full freezes the whole pipeline,
// and req_stall rises in the same cycle.
// Reset: synchronous; clears all CSRs, the chain register and every valid bit.
module aes128_ctr_cbc_block_decryptor (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  aescd_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output aescd_pkg::rsp_type rsp_data,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_data
);

   logic [63:0]         key_high_ff, key_low_ff, iv_high_ff, iv_low_ff;
   logic                cipher_mode_ff;
   logic [127:0]        chain_ff;
   logic [127:0]        chain_in;
   logic [127:0]        chain_eff;
   logic                advance;
   logic                accept;
   logic [1:0]          status;
   logic                run;
   logic [5:0]          lane_end;
   logic [127:0]        data_blk;
   logic [127:0]        key_blk;
   aescd_pkg::pipe_type entry_in;
   logic                entry_valid_ff;
   aescd_pkg::pipe_type entry_ff;
   logic                stage_valid [aescd_pkg::NUM_STAGES+1];
   aescd_pkg::pipe_type stage_pipe  [aescd_pkg::NUM_STAGES+1];
   logic                rsp_valid_ff;
   aescd_pkg::rsp_type  rsp_ff;
   aescd_pkg::rsp_type  rsp_in;
   logic [127:0]        plain;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;
   assign data_blk  = {req_data.data_high, req_data.data_low};
   assign key_blk   = {key_high_ff, key_low_ff};

   always_comb begin
      if (cipher_mode_ff == aescd_pkg::MODE_CBC && req_data.start_offset != 4'd0) begin
         status = aescd_pkg::STATUS_OFFSET;
      end else if (cipher_mode_ff == aescd_pkg::MODE_CBC && req_data.byte_count != 5'd0 &&
                   req_data.byte_count != 5'd16) begin
         status = aescd_pkg::STATUS_PARTIAL;
      end else begin
         status = aescd_pkg::STATUS_OK;
      end
      run       = (status == aescd_pkg::STATUS_OK) && (req_data.byte_count != 5'd0);
      chain_eff = (status == aescd_pkg::STATUS_OK && req_data.restart) ?
                  {iv_high_ff, iv_low_ff} : chain_ff;
      chain_in  = chain_eff;
      if (run) begin
         if (cipher_mode_ff == aescd_pkg::MODE_CTR) begin
            chain_in = {chain_eff[127:64], chain_eff[63:0] + 64'd1};
         end else begin
            chain_in = data_blk;
         end
      end
      lane_end         = {2'b00, req_data.start_offset} + {1'b0, req_data.byte_count};
      entry_in.mode    = cipher_mode_ff;
      entry_in.status  = status;
      entry_in.rkey    = key_blk;
      for (int i = 0; i < aescd_pkg::BLOCK_BYTES; i++) begin
         if (cipher_mode_ff == aescd_pkg::MODE_CTR) begin
            entry_in.lane_mask[i] = (6'(i) >= {2'b00, req_data.start_offset}) &&
                                    (6'(i) < lane_end);
         end else begin
            entry_in.lane_mask[i] = run;
         end
      end
      if (cipher_mode_ff == aescd_pkg::MODE_CTR) begin
         entry_in.state   = chain_eff ^ key_blk;
         entry_in.xor_val = data_blk;
      end else begin
         entry_in.state   = data_blk;
         entry_in.xor_val = chain_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff    <= 64'd0;
         key_low_ff     <= 64'd0;
         iv_high_ff     <= 64'd0;
         iv_low_ff      <= 64'd0;
         cipher_mode_ff <= aescd_pkg::MODE_CTR;
         chain_ff       <= 128'd0;
         entry_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               aescd_pkg::CSR_KEY_HIGH:    key_high_ff    <= csr_data;
               aescd_pkg::CSR_KEY_LOW:     key_low_ff     <= csr_data;
               aescd_pkg::CSR_IV_HIGH:     iv_high_ff     <= csr_data;
               aescd_pkg::CSR_IV_LOW:      iv_low_ff      <= csr_data;
               aescd_pkg::CSR_CIPHER_MODE: cipher_mode_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (accept) begin
            chain_ff <= chain_in;
         end
         if (advance) begin
            entry_valid_ff <= accept;
            rsp_valid_ff   <= stage_valid[aescd_pkg::NUM_STAGES];
         end
      end
      if (advance) begin
         entry_ff <= entry_in;
         rsp_ff   <= rsp_in;
      end
   end

   assign stage_valid[0] = entry_valid_ff;
   assign stage_pipe[0]  = entry_ff;

   for (genvar g = 0; g < aescd_pkg::NUM_STAGES; g++) begin : g_stage
      aescd_pkg::stage_ctl_type ctl;
      if (g < aescd_pkg::NUM_ROUNDS) begin : g_fwd
         assign ctl.rcon     = aescd_pkg::RCON[g];
         assign ctl.last_fwd = (g == aescd_pkg::NUM_ROUNDS - 1);
         assign ctl.bwd      = 1'b0;
         assign ctl.mix      = 1'b0;
      end else begin : g_bwd
         assign ctl.rcon     = aescd_pkg::RCON[aescd_pkg::NUM_STAGES - 1 - g];
         assign ctl.last_fwd = 1'b0;
         assign ctl.bwd      = 1'b1;
         assign ctl.mix      = (g != aescd_pkg::NUM_STAGES - 1);
      end
      aescd_round_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .ctl       (ctl),
         .valid_in  (stage_valid[g]),
         .pipe_in   (stage_pipe[g]),
         .valid_out (stage_valid[g+1]),
         .pipe_out  (stage_pipe[g+1])
      );
   end

   always_comb begin
      for (int i = 0; i < aescd_pkg::BLOCK_BYTES; i++) begin
         plain[127-8*i -: 8] = stage_pipe[aescd_pkg::NUM_STAGES].lane_mask[i] ?
            (stage_pipe[aescd_pkg::NUM_STAGES].state[127-8*i -: 8] ^
             stage_pipe[aescd_pkg::NUM_STAGES].xor_val[127-8*i -: 8]) : 8'h00;
      end
      rsp_in.plain_high = plain[127:64];
      rsp_in.plain_low  = plain[63:0];
      rsp_in.status     = stage_pipe[aescd_pkg::NUM_STAGES].status;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_error_zero_plain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != aescd_pkg::STATUS_OK) |->
      (rsp_data.plain_high == 64'd0 && rsp_data.plain_low == 64'd0))
      else $error("error response carries plaintext");

   a_error_keeps_chain: assert property (@(posedge clock) disable iff (reset)
      (accept && status != aescd_pkg::STATUS_OK) |=> $stable(chain_ff))
      else $error("rejected transaction changed the chain");

   a_ctr_increment: assert property (@(posedge clock) disable iff (reset)
      (accept && cipher_mode_ff == aescd_pkg::MODE_CTR && !req_data.restart &&
       req_data.byte_count != 5'd0) |=>
      (chain_ff[63:0] == $past(chain_ff[63:0]) + 64'd1))
      else $error("counter did not advance");

endmodule
